/* design/rau_pkg.sv */
package rau_pkg;
  localparam int unsigned DefWordBits = 32;

  typedef enum logic [1:0] {
    CmdAdd = 2'd0,
    CmdSub = 2'd1,
    CmdMul = 2'd2,
    CmdDiv = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StZeroDen  = 2'd1,
    StDivZero  = 2'd2,
    StOverflow = 2'd3
  } status_e;
endpackage

/* design/rau_front.sv */
module rau_front import rau_pkg::*; #(
  parameter int unsigned WordBits = DefWordBits
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [1:0]            command_i,
  input  logic [31:0]           left_numer_i,
  input  logic [31:0]           left_denom_i,
  input  logic [31:0]           right_numer_i,
  input  logic [31:0]           right_denom_i,
  output logic                  q_valid_o,
  input  logic                  q_pop_i,
  output logic [1:0]            q_cmd_o,
  output logic                  q_sa_o,
  output logic                  q_sb_o,
  output logic [WordBits-1:0]   q_man_o,
  output logic [WordBits-1:0]   q_mad_o,
  output logic [WordBits-1:0]   q_mbn_o,
  output logic [WordBits-1:0]   q_mbd_o,
  output logic [1:0]            q_status_o
);
  typedef struct packed {
    logic [1:0]          cmd;
    logic                sa;
    logic                sb;
    logic [WordBits-1:0] man;
    logic [WordBits-1:0] mad;
    logic [WordBits-1:0] mbn;
    logic [WordBits-1:0] mbd;
    logic [1:0]          status;
  } entry_t;

  entry_t ent_d, ent_q;
  logic   valid_q;

  function automatic logic [WordBits-1:0] mag(input logic [WordBits-1:0] v);
    mag = v[WordBits-1] ? (~v + 1'b1) : v;
  endfunction

  assign busy_o = valid_q;

  always_comb begin
    ent_d.cmd = command_i;
    ent_d.man = mag(left_numer_i[WordBits-1:0]);
    ent_d.mad = mag(left_denom_i[WordBits-1:0]);
    ent_d.mbn = mag(right_numer_i[WordBits-1:0]);
    ent_d.mbd = mag(right_denom_i[WordBits-1:0]);
    ent_d.sa  = left_numer_i[WordBits-1] ^ left_denom_i[WordBits-1];
    ent_d.sb  = right_numer_i[WordBits-1] ^ right_denom_i[WordBits-1];
    if (ent_d.mad == '0 || ent_d.mbd == '0) begin
      ent_d.status = StZeroDen;
    end else if (command_i == CmdDiv && ent_d.mbn == '0) begin
      ent_d.status = StDivZero;
    end else begin
      ent_d.status = StOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (start_i && !valid_q) begin
      valid_q <= 1'b1;
    end else if (q_pop_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !valid_q) begin
      ent_q <= ent_d;
    end
  end

  assign q_valid_o  = valid_q;
  assign q_cmd_o    = ent_q.cmd;
  assign q_sa_o     = ent_q.sa;
  assign q_sb_o     = ent_q.sb;
  assign q_man_o    = ent_q.man;
  assign q_mad_o    = ent_q.mad;
  assign q_mbn_o    = ent_q.mbn;
  assign q_mbd_o    = ent_q.mbd;
  assign q_status_o = ent_q.status;
endmodule

/* design/rau_back.sv */
module rau_back import rau_pkg::*; #(
  parameter int unsigned WordBits = DefWordBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  output logic                q_pop_o,
  input  logic [1:0]          q_cmd_i,
  input  logic                q_sa_i,
  input  logic                q_sb_i,
  input  logic [WordBits-1:0] q_man_i,
  input  logic [WordBits-1:0] q_mad_i,
  input  logic [WordBits-1:0] q_mbn_i,
  input  logic [WordBits-1:0] q_mbd_i,
  input  logic [1:0]          q_status_i,
  output logic                done_o,
  output logic [31:0]         result_numer_o,
  output logic [30:0]         result_denom_o,
  output logic [1:0]          status_o
);
  localparam int unsigned PW = 2 * WordBits;
  localparam int unsigned RW = PW + 1;
  localparam int unsigned CW = $clog2(PW + 1);
  localparam logic [RW-1:0] Limit = RW'((64'd1 << (WordBits - 1)) - 64'd1);

  typedef enum logic [8:0] {
    SIdle  = 9'b000000001,
    SMul1  = 9'b000000010,
    SMul2  = 9'b000000100,
    SComb  = 9'b000001000,
    SGcd   = 9'b000010000,
    SDivN  = 9'b000100000,
    SDivD  = 9'b001000000,
    SFin   = 9'b010000000,
    SOut   = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [PW-1:0] p1_q, p2_q, p3_q;
  logic [RW-1:0] num_q, den_q, ga_q, gb_q;
  logic          neg_q;
  logic [1:0]    st_q;
  // shared restoring divider
  logic [RW-1:0] dv_n_q, dv_d_q, dv_r_q;
  logic [CW-1:0] dv_cnt_q;
  logic          dv_run_q;
  logic [RW:0]   dv_rs;
  logic [RW-1:0] dv_r_next;
  logic          dv_ge;

  logic [WordBits-1:0] ma, mb;
  logic [PW-1:0]       prod;

  logic [RW+31:0] num_x, num_neg, den_x;

  logic [31:0] rn_q;
  logic [30:0] rd_q;
  logic        done_q;

  assign prod = PW'(ma) * PW'(mb);
  assign dv_rs = {dv_r_q, dv_n_q[RW-1]};
  assign dv_ge = dv_rs >= {1'b0, dv_d_q};
  assign dv_r_next = dv_ge ? RW'(dv_rs - {1'b0, dv_d_q}) : RW'(dv_rs);

  assign num_x   = {32'd0, num_q};
  assign num_neg = -num_x;
  assign den_x   = {32'd0, den_q};

  always_comb begin
    unique case (state_q)
      SMul1: begin
        ma = q_man_i;
        mb = (q_cmd_i == CmdMul) ? q_mbn_i : q_mbd_i;
      end
      SMul2: begin
        ma = (q_cmd_i == CmdMul) ? q_mad_i : q_mbn_i;
        mb = (q_cmd_i == CmdMul) ? q_mbd_i : q_mad_i;
      end
      default: begin
        ma = q_mad_i;
        mb = q_mbd_i;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SIdle: if (q_valid_i) state_d = (q_status_i != StOk) ? SFin : SMul1;
      SMul1: state_d = SMul2;
      SMul2: state_d = SComb;
      SComb: state_d = SGcd;
      SGcd:  if (!dv_run_q && gb_q == '0) state_d = SDivN;
      SDivN: if (dv_run_q && dv_cnt_q == '0) state_d = SDivD;
      SDivD: if (dv_run_q && dv_cnt_q == '0) state_d = SFin;
      SFin:  state_d = SOut;
      SOut:  state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      dv_run_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == SOut);
      if (dv_run_q) begin
        if (dv_cnt_q == '0) dv_run_q <= 1'b0;
      end else if ((state_q == SGcd && gb_q != '0) || state_q == SDivN
                   || state_q == SDivD) begin
        dv_run_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      SIdle: st_q <= q_status_i;
      SMul1: p1_q <= prod;
      SMul2: p2_q <= prod;
      SComb: begin
        if (q_cmd_i == CmdAdd || q_cmd_i == CmdSub) begin
          logic nb;
          nb = (q_cmd_i == CmdSub) ? !q_sb_i : q_sb_i;
          if (q_sa_i == nb) begin
            num_q <= {1'b0, p1_q} + {1'b0, p2_q};
            neg_q <= q_sa_i;
          end else if (p1_q >= p2_q) begin
            num_q <= {1'b0, p1_q - p2_q};
            neg_q <= q_sa_i;
          end else begin
            num_q <= {1'b0, p2_q - p1_q};
            neg_q <= nb;
          end
          den_q <= {1'b0, p3_q};
          ga_q  <= (q_sa_i == nb) ? ({1'b0, p1_q} + {1'b0, p2_q})
                 : (p1_q >= p2_q) ? {1'b0, p1_q - p2_q} : {1'b0, p2_q - p1_q};
          gb_q  <= {1'b0, p3_q};
        end else begin
          num_q <= {1'b0, p1_q};
          den_q <= {1'b0, p2_q};
          ga_q  <= {1'b0, p1_q};
          gb_q  <= {1'b0, p2_q};
          neg_q <= q_sa_i ^ q_sb_i;
        end
      end
      default: ;
    endcase
    if (state_q == SMul1) p3_q <= PW'(q_mad_i) * PW'(q_mbd_i);
    if (dv_run_q) begin
      dv_r_q   <= dv_r_next;
      dv_n_q   <= {dv_n_q[RW-2:0], dv_ge};
      dv_cnt_q <= dv_cnt_q - 1'b1;
      if (dv_cnt_q == '0 && state_q == SGcd) begin
        ga_q <= gb_q;
        gb_q <= dv_r_next;
      end
      if (dv_cnt_q == '0 && state_q == SDivN) num_q <= {dv_n_q[RW-2:0], dv_ge};
      if (dv_cnt_q == '0 && state_q == SDivD) den_q <= {dv_n_q[RW-2:0], dv_ge};
    end else begin
      dv_r_q   <= '0;
      dv_cnt_q <= CW'(RW - 1);
      unique case (state_q)
        SGcd: begin
          dv_n_q <= ga_q;
          dv_d_q <= gb_q;
        end
        SDivN: begin
          dv_n_q <= num_q;
          dv_d_q <= (ga_q == '0) ? RW'(1) : ga_q;
        end
        SDivD: begin
          dv_n_q <= den_q;
          dv_d_q <= (ga_q == '0) ? RW'(1) : ga_q;
        end
        default: ;
      endcase
    end
    if (state_q == SFin) begin
      if (st_q != StOk) begin
        rn_q <= '0;
        rd_q <= 31'd1;
        status_o <= st_q;
      end else if (num_q == '0) begin
        rn_q <= '0;
        rd_q <= 31'd1;
        status_o <= StOk;
      end else if (num_q > Limit || den_q > Limit) begin
        rn_q <= '0;
        rd_q <= 31'd1;
        status_o <= StOverflow;
      end else begin
        rn_q <= neg_q ? num_neg[31:0] : num_x[31:0];
        rd_q <= den_x[30:0];
        status_o <= StOk;
      end
    end
  end

  assign q_pop_o        = (state_q == SOut);
  assign done_o         = done_q;
  assign result_numer_o = rn_q;
  assign result_denom_o = rd_q;
endmodule

/* design/rational_arith_unit.sv */
// channel  | handshake       | ports
// command  | start, busy     | command_i, left_*_i, right_*_i
// result   | done_o strobe   | result_numer_o, result_denom_o, status_o
// An item's time is set by the restoring divider, which the Euclid loop and the
// two final divisions share.
// Zero-denominator and divide-by-zero errors skip the math.
// Reset clears the queue slot and the back-end sequencer.
// busy stays high from accept until the result strobe; results cannot stall.
module rational_arith_unit import rau_pkg::*; #(
  parameter int unsigned WordBits = DefWordBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command_i,
  input  logic [31:0] left_numer_i,
  input  logic [31:0] left_denom_i,
  input  logic [31:0] right_numer_i,
  input  logic [31:0] right_denom_i,
  output logic        done_o,
  output logic [31:0] result_numer_o,
  output logic [30:0] result_denom_o,
  output logic [1:0]  status_o
);
  logic                q_valid, q_pop, q_sa, q_sb;
  logic [1:0]          q_cmd, q_status;
  logic [WordBits-1:0] q_man, q_mad, q_mbn, q_mbd;
  logic                f_busy;

  rau_front #(.WordBits(WordBits)) u_front (
    .clk_i, .rst_ni, .start_i(start), .busy_o(f_busy),
    .command_i, .left_numer_i, .left_denom_i, .right_numer_i, .right_denom_i,
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_cmd_o(q_cmd), .q_sa_o(q_sa),
    .q_sb_o(q_sb), .q_man_o(q_man), .q_mad_o(q_mad), .q_mbn_o(q_mbn),
    .q_mbd_o(q_mbd), .q_status_o(q_status)
  );

  rau_back #(.WordBits(WordBits)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_pop_o(q_pop), .q_cmd_i(q_cmd),
    .q_sa_i(q_sa), .q_sb_i(q_sb), .q_man_i(q_man), .q_mad_i(q_mad),
    .q_mbn_i(q_mbn), .q_mbd_i(q_mbd), .q_status_i(q_status),
    .done_o, .result_numer_o, .result_denom_o, .status_o
  );

  assign busy = f_busy;
endmodule

/* sim/rational_arith_unit_test.sv */
`timescale 1ns / 100ps

module rational_arith_unit_test;
  import rau_pkg::*;

  localparam longint unsigned WordLimit = 64'h7FFF_FFFF;
  localparam longint CycleLimit = 64'd30_000_000;

  typedef struct {
    logic [31:0] numer;
    logic [30:0] denom;
    status_e     status;
  } fraction_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  command_i = '0;
  logic [31:0] left_numer_i = '0;
  logic [31:0] left_denom_i = '0;
  logic [31:0] right_numer_i = '0;
  logic [31:0] right_denom_i = '0;
  logic        done_o;
  logic [31:0] result_numer_o;
  logic [30:0] result_denom_o;
  logic [1:0]  status_o;

  fraction_t   pending_fractions[$];
  int          beats_sent;
  int          beats_checked;
  int          mismatches;
  int          status_seen[4];
  longint      cycle_count;

  rational_arith_unit dut (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .command_i,
    .left_numer_i,
    .left_denom_i,
    .right_numer_i,
    .right_denom_i,
    .done_o,
    .result_numer_o,
    .result_denom_o,
    .status_o
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  function automatic longint unsigned word_mag(logic [31:0] w);
    logic [31:0] m;
    m = w[31] ? -w : w;
    return {32'd0, m};
  endfunction

  function automatic fraction_t reduce_fraction(cmd_e cmd, logic [31:0] an, logic [31:0] ad,
                                                logic [31:0] bn, logic [31:0] bd);
    fraction_t r;
    longint unsigned man, mad, mbn, mbd, num, den, g, a, b, t, p, q;
    logic sa, sb, sb2, neg;
    man = word_mag(an);
    mad = word_mag(ad);
    mbn = word_mag(bn);
    mbd = word_mag(bd);
    sa = an[31] ^ ad[31];
    sb = bn[31] ^ bd[31];
    r.status = StOk;
    neg = 1'b0;
    num = 0;
    den = 1;
    if (mad == 0 || mbd == 0) begin
      r.status = StZeroDen;
    end else if (cmd == CmdAdd || cmd == CmdSub) begin
      sb2 = (cmd == CmdSub) ? ~sb : sb;
      p = man * mbd;
      q = mbn * mad;
      if (sa == sb2) begin
        neg = sa;
        num = p + q;
      end else if (p >= q) begin
        neg = sa;
        num = p - q;
      end else begin
        neg = sb2;
        num = q - p;
      end
      den = mad * mbd;
    end else if (cmd == CmdMul) begin
      neg = sa ^ sb;
      num = man * mbn;
      den = mad * mbd;
    end else if (mbn == 0) begin
      r.status = StDivZero;
    end else begin
      neg = sa ^ sb;
      num = man * mbd;
      den = mad * mbn;
    end
    if (r.status == StOk) begin
      a = num;
      b = den;
      while (b != 0) begin
        t = a % b;
        a = b;
        b = t;
      end
      g = a;
      if (g != 0) begin
        num = num / g;
        den = den / g;
      end
      if (num == 0) begin
        neg = 1'b0;
        den = 1;
      end
      if (num > WordLimit || den > WordLimit) r.status = StOverflow;
    end
    if (r.status != StOk) begin
      r.numer = '0;
      r.denom = 31'd1;
    end else begin
      r.numer = neg ? -num[31:0] : num[31:0];
      r.denom = den[30:0];
    end
    return r;
  endfunction

  task automatic send_operation(cmd_e cmd, logic [31:0] an, logic [31:0] ad,
                                logic [31:0] bn, logic [31:0] bd);
    int gap;
    gap = $urandom_range(0, 8);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    command_i <= cmd;
    left_numer_i <= an;
    left_denom_i <= ad;
    right_numer_i <= bn;
    right_denom_i <= bd;
    do @(posedge clk_i); while (busy);
    pending_fractions.push_back(reduce_fraction(cmd, an, ad, bn, bd));
    beats_sent++;
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_fractions.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    fraction_t exp_f;
    if (done_o) begin
      if (pending_fractions.size() == 0) begin
        $error("result beat with nothing pending");
        mismatches++;
      end else begin
        exp_f = pending_fractions.pop_front();
        beats_checked++;
        status_seen[status_o]++;
        if (status_o !== exp_f.status) begin
          $error("status: expected %0d actual %0d", exp_f.status, status_o);
          mismatches++;
        end
        if (result_numer_o !== exp_f.numer) begin
          $error("result_numer: expected %0d actual %0d",
                 $signed(exp_f.numer), $signed(result_numer_o));
          mismatches++;
        end
        if (result_denom_o !== exp_f.denom) begin
          $error("result_denom: expected %0d actual %0d", exp_f.denom, result_denom_o);
          mismatches++;
        end
      end
    end
  end

  function automatic logic [31:0] small_word(int span);
    return 32'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic logic [31:0] any_word();
    return $urandom();
  endfunction

  task automatic test_directed();
    cmd_e cmd;
    for (int c = 0; c < 4; c++) begin
      cmd = cmd_e'(c);
      send_operation(cmd, 32'd1, 32'd2, 32'd1, 32'd3);
      send_operation(cmd, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0001, 32'h7FFF_FFFF);
      send_operation(cmd, 32'h8000_0000, 32'd1, 32'h8000_0000, 32'hFFFF_FFFF);
      send_operation(cmd, 32'd5, 32'd0, 32'd1, 32'd1);
    end
    send_operation(CmdAdd, 32'd1, 32'd1, 32'd1, 32'd0);
    send_operation(CmdDiv, 32'd3, 32'd4, 32'd0, 32'd7);
    send_operation(CmdDiv, 32'd0, 32'd0, 32'd0, 32'd0);
    send_operation(CmdMul, 32'd0, 32'hFFFF_FFF9, 32'd9, 32'd2);
    send_operation(CmdSub, 32'd3, 32'd8, 32'd3, 32'd8);
    send_operation(CmdAdd, 32'd3, 32'd10, 32'hFFFF_FFFF, 32'd10);
    send_operation(CmdMul, 32'h7FFF_FFFF, 32'd1, 32'd2, 32'd1);
    send_operation(CmdDiv, 32'd1, 32'h7FFF_FFFF, 32'd2, 32'd1);
    send_operation(CmdAdd, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF, 32'd1);
  endtask

  task automatic test_pressure();
    drain_results();
    send_operation(CmdDiv, 32'hFFFF_FFF4, 32'd18, 32'd4, 32'hFFFF_FFFA);
    drain_results();
  endtask

  task automatic test_random(int count);
    logic [31:0] w[4];
    int kind;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(0, 19);
      for (int k = 0; k < 4; k++) begin
        if (kind < 13) w[k] = small_word(1000);
        else if (kind < 17) w[k] = ($urandom_range(0, 1)) ? small_word(20) : any_word();
        else w[k] = any_word();
      end
      if ($urandom_range(0, 39) == 0) w[1 + 2 * $urandom_range(0, 1)] = '0;
      if ($urandom_range(0, 29) == 0) w[2] = '0;
      if ($urandom_range(0, 9) == 0) w[3] = w[1];
      send_operation(cmd_e'($urandom_range(0, 3)), w[0], w[1], w[2], w[3]);
    end
  endtask

  initial begin
    cycle_count = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_directed();
    test_pressure();
    test_random(1300);
    drain_results();
    repeat (50) @(posedge clk_i);
    $display("covered %0d operations, %0d results checked in %0d cycles",
             beats_sent, beats_checked, cycle_count);
    $display("status mix ok/zero-den/div-zero/overflow: %0d/%0d/%0d/%0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (mismatches == 0 && pending_fractions.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
